FILE: hw/rtl/tkee_pkg.sv
// ----------------------------------------------------------------------------
// tkee_pkg: shared types and constants of the touch key event encoder
// Beat structs, configuration register map, key masks and the key encoder.
// ----------------------------------------------------------------------------
package tkee_pkg;

  // Number of keys on the full pad (8 to 16).
  localparam int KEY_COUNT = 16;
  // Width of the scanned mask field.
  localparam int KEY_W = 16;
  // Width of a key number (0 = no event, 1..16).
  localparam int KEY_NUM_W = 5;

  localparam logic [KEY_W-1:0] MASK_LOW8 = 16'h00FF;
  localparam logic [KEY_W-1:0] MASK_FULL = KEY_W'((1 << KEY_COUNT) - 1);

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register map.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_KEYS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_READY_EDGE = 1'b1;

  // Input command codes.
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef enum logic {
    OP_EDGE,
    OP_POLL
  } op_e;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key_mask;
    logic             line_low_after;
  } in_beat_t;

  typedef struct packed {
    logic [KEY_NUM_W-1:0] key_number;
    logic                 is_release;
    logic                 more_pending;
  } out_beat_t;

  typedef struct packed {
    logic sixteen_keys;
    logic use_ready_edge;
  } cfg_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] keys;
    logic             low_after;
  } queue_entry_t;

  // Number (1..16) of the lowest set bit; 0 if the set is empty.
  function automatic logic [KEY_NUM_W-1:0] key_number_of(logic [KEY_W-1:0] set);
    logic [KEY_NUM_W-1:0] n;
    n = '0;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      if (set[i]) begin
        n = KEY_NUM_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/tkee_front.sv
// ----------------------------------------------------------------------------
// tkee_front: input classification
// Accepts input beats, drops unwatched edges, masks unused keys and queues.
// ----------------------------------------------------------------------------
module tkee_front (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tkee_pkg::in_beat_t     in_data_i,
  input  tkee_pkg::cfg_t         cfg_i,
  output logic                   push_o,
  output tkee_pkg::queue_entry_t push_data_o,
  input  logic                   queue_ready_i
);
  import tkee_pkg::*;

  logic drop;

  // With edge watching off, edge items have no effect at all.
  assign drop       = (in_data_i.cmd == CMD_EDGE) && !cfg_i.use_ready_edge;
  assign in_ready_o = queue_ready_i;
  assign push_o     = in_valid_i && queue_ready_i && !drop;

  always_comb begin
    push_data_o.op        = (in_data_i.cmd == CMD_POLL) ? OP_POLL : OP_EDGE;
    push_data_o.keys      = in_data_i.key_mask &
                            (cfg_i.sixteen_keys ? MASK_FULL : MASK_LOW8);
    push_data_o.low_after = in_data_i.line_low_after;
  end

endmodule

FILE: hw/rtl/tkee_queue.sv
// ----------------------------------------------------------------------------
// tkee_queue: short register queue
// Holds classified items between the front and the back.
// ----------------------------------------------------------------------------
module tkee_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tkee_pkg::queue_entry_t push_data_i,
  output logic                   ready_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output tkee_pkg::queue_entry_t pop_data_o
);
  import tkee_pkg::*;

  queue_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wptr_q, wptr_d;
  logic [QPTR_W-1:0]       rptr_q, rptr_d;
  logic [QCNT_W-1:0]       cnt_q, cnt_d;
  logic                    do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign ready_o    = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? ptr_next(wptr_q) : wptr_q;
    rptr_d = do_pop ? ptr_next(rptr_q) : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/tkee_back.sv
// ----------------------------------------------------------------------------
// tkee_back: event engine
// Keeps the key state, turns queued items into events and holds the result.
// ----------------------------------------------------------------------------
module tkee_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tkee_pkg::cfg_t         cfg_i,
  input  logic                   queue_valid_i,
  input  tkee_pkg::queue_entry_t queue_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tkee_pkg::out_beat_t    out_data_o
);
  import tkee_pkg::*;

  logic [KEY_W-1:0] reported_q, reported_d;
  logic [KEY_W-1:0] unrep_q, unrep_d;
  logic             pending_q, pending_d;
  logic             ignore_q, ignore_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_data_q;
  out_beat_t        result;

  logic             produces, slot_free;
  logic [KEY_W-1:0] cur, changes, pressed, released;
  logic [KEY_W-1:0] press_bit, release_bit;
  logic             more;

  assign produces  = (queue_data_i.op == OP_POLL) && !(cfg_i.use_ready_edge && !pending_q);
  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = queue_valid_i && (!produces || slot_free);

  // Change detection; x & -x isolates the lowest set bit.
  always_comb begin
    cur         = queue_data_i.keys | unrep_q;
    changes     = reported_q ^ cur;
    pressed     = changes & cur;
    released    = changes & reported_q;
    press_bit   = pressed & (~pressed + KEY_W'(1));
    release_bit = released & (~released + KEY_W'(1));
  end

  always_comb begin
    reported_d = reported_q;
    unrep_d    = unrep_q;
    pending_d  = pending_q;
    ignore_d   = ignore_q;
    more       = 1'b0;
    result     = '0;
    if (pop_o) begin
      if (queue_data_i.op == OP_EDGE) begin
        if (ignore_q) begin
          ignore_d = 1'b0;
        end else begin
          pending_d = 1'b1;
        end
      end else if (produces) begin
        if (pressed != '0) begin
          result.key_number = key_number_of(press_bit);
          more              = (pressed & ~press_bit) != '0;
          reported_d        = reported_q | press_bit;
          unrep_d           = cur & ~(reported_q | press_bit);
        end else if (released != '0) begin
          result.key_number = key_number_of(release_bit);
          result.is_release = 1'b1;
          more              = (released & ~release_bit) != '0;
          reported_d        = reported_q & ~release_bit;
        end
        pending_d           = more;
        result.more_pending = more;
        ignore_d            = queue_data_i.low_after;
      end
    end
  end

  always_comb begin
    if (pop_o && produces) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reported_q  <= '0;
      unrep_q     <= '0;
      pending_q   <= 1'b0;
      ignore_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      reported_q  <= reported_d;
      unrep_q     <= unrep_d;
      pending_q   <= pending_d;
      ignore_q    <= ignore_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && produces) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/touch_key_event_encoder_top.sv
// ----------------------------------------------------------------------------
// touch_key_event_encoder_top: touch key press/release event encoder
// Turns sampled touch key masks into single press and release events.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle while the queue has room: either a
// data-ready edge or a poll that carries the scanned key mask. An evaluated
// poll gives exactly one output beat, naming the lowest newly pressed key, or
// else the lowest released key, or key number 0 when nothing changed; edges
// and gated polls give no output beat. Throughput is one beat per cycle while
// the output is not stalled. From acceptance to the output a beat passes the
// two-entry queue register behind the classifier and then the output register
// of the event engine. A stalled output only holds up input once the queue is
// full. Configuration writes take effect at the next clock edge and must be
// made while no beat is in flight.
module touch_key_event_encoder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tkee_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tkee_pkg::out_beat_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [tkee_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                 cfg_data_i
);
  import tkee_pkg::*;

  cfg_t         cfg_q, cfg_d;
  logic         push, queue_ready, pop, queue_valid;
  queue_entry_t push_data, pop_data;

  // Configuration registers; both reset to one.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIXTEEN_KEYS:   cfg_d.sixteen_keys   = cfg_data_i;
        CFG_USE_READY_EDGE: cfg_d.use_ready_edge = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sixteen_keys: 1'b1, use_ready_edge: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front classifies each beat and masks keys that are not in use.
  tkee_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg_q),
    .push_o       (push),
    .push_data_o  (push_data),
    .queue_ready_i(queue_ready)
  );

  // The queue lets the front keep accepting while the output stalls.
  tkee_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .ready_o    (queue_ready),
    .pop_i      (pop),
    .valid_o    (queue_valid),
    .pop_data_o (pop_data)
  );

  // The back owns the key state and the output register.
  tkee_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .queue_valid_i(queue_valid),
    .queue_data_i (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: hw/rtl/tkee_checker.sv
// ----------------------------------------------------------------------------
// tkee_checker: port level checks of the touch key event encoder
// Watches the top level ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
module tkee_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input tkee_pkg::in_beat_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input tkee_pkg::out_beat_t  out_data_o
);
  import tkee_pkg::*;

  // No output beat is offered in the cycle after reset was applied.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output beat offered after reset");

  // A waiting input beat stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("waiting input beat changed");

  // A stalled output beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // An empty event is neither a release nor followed by more events.
  a_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.key_number == '0) |->
      !out_data_o.is_release && !out_data_o.more_pending)
    else $error("empty event carries flags");

  // Key numbers stay within the pad.
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.key_number <= KEY_NUM_W'(KEY_COUNT)))
    else $error("key number beyond the pad");

endmodule

bind touch_key_event_encoder_top tkee_checker u_checker (.*);
